@@ design/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ design/ftlb_pkg.sv @@
package ftlb_pkg;

   // Operation codes carried in the request tuser.
   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_ERASE  = 2'd2
   } ftlb_op_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_FINISH = 2'd2
   } ftlb_state_type;

   // Control part of the search token that walks the cell chain.
   // done: lookup/erase matched, or insert found a free entry.
   typedef struct packed {
      logic       valid;
      logic [1:0] op;
      logic       done;
   } ftlb_tok_type;

   // Register map.
   localparam logic CSR_ENTRIES_IN_USE = 1'b0;
   localparam int   CSR_DATA_BITS      = 32;
   localparam int   ENTRY_CNT_BITS     = 5;
   localparam logic [ENTRY_CNT_BITS-1:0] ENTRIES_RESET = 5'd16;

   // Width of the hit and miss counters.
   localparam int   COUNT_BITS = 32;

endpackage

@@ design/fully_associative_tlb_lru.sv @@
// Fully associative TLB with least-recently-used replacement. Each request
// (lookup, insert or erase) runs as a search token through a chain of
// TABLE_ENTRIES cells, one cell per cycle starting in the cycle of acceptance,
// each cell holding one entry; the sequencer then captures the token and,
// once the output register is free, applies the insert write and updates
// the hit and miss counters. The block takes a new request only after the
// previous one has updated the counters. The response sits in an output
// register; the next request is taken while it waits, and holds at the
// end of its scan until that register drains. Valid bits reset at once, so
// there is no clearing pass. Register 0 (byte address 0) holds entries_in_use:
// 0 acts as 1 and values above TABLE_ENTRIES act as TABLE_ENTRIES. Write it
// only while the block is idle.
module fully_associative_tlb_lru #(
   parameter int TABLE_ENTRIES = 16,
   parameter int PAGE_BITS     = 20,
   parameter int STAMP_BITS    = 32
) (
   input  logic clock,
   input  logic reset,
   // request: tuser = operation[1:0]
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_tuser,
   // request tdata, low bit up: virtual_page, physical_page, timestamp, zero pad
   input  logic [((2*PAGE_BITS+STAMP_BITS+7)/8)*8-1:0] req_tdata,
   // response: tuser = found
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic                 rsp_tuser,
   // response tdata, low bit up: translated_page, hit_total, miss_total, zero pad
   output logic [((PAGE_BITS+2*ftlb_pkg::COUNT_BITS+7)/8)*8-1:0] rsp_tdata,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [ftlb_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [ftlb_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic        pready
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int OUT_W = ((PAGE_BITS + 2*ftlb_pkg::COUNT_BITS + 7) / 8) * 8;

   // configuration register
   logic [ftlb_pkg::ENTRY_CNT_BITS-1:0] entries_ff;
   logic csr_write;
   logic csr_hit;

   assign csr_hit   = (paddr[2] == ftlb_pkg::CSR_ENTRIES_IN_USE);
   assign csr_write = psel && penable && pwrite && csr_hit;
   assign pready    = 1'b1;
   assign prdata    = csr_hit ? ftlb_pkg::CSR_DATA_BITS'(entries_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) entries_ff <= ftlb_pkg::ENTRIES_RESET;
      else if (csr_write) entries_ff <= pwdata[ftlb_pkg::ENTRY_CNT_BITS-1:0];
   end

   // clamp the entry count
   logic [31:0]      eff_wide;
   logic [CNT_W-1:0] eff_count;
   always_comb begin
      if (entries_ff == '0) eff_wide = 32'd1;
      else if (32'(entries_ff) > 32'(TABLE_ENTRIES)) eff_wide = 32'(TABLE_ENTRIES);
      else eff_wide = 32'(entries_ff);
   end
   assign eff_count = eff_wide[CNT_W-1:0];

   // request payload and token entering the chain
   logic req_accept;
   ftlb_pkg::ftlb_tok_type head_tok;
   assign req_accept     = req_tvalid && req_tready;
   assign head_tok.valid = req_accept;
   assign head_tok.op    = req_tuser;
   assign head_tok.done  = 1'b0;

   // chain wiring: index i is the output of cell i
   ftlb_pkg::ftlb_tok_type tok_c [TABLE_ENTRIES];
   logic [PAGE_BITS-1:0]  vpage_c  [TABLE_ENTRIES];
   logic [PAGE_BITS-1:0]  ppage_c  [TABLE_ENTRIES];
   logic [STAMP_BITS-1:0] stamp_c  [TABLE_ENTRIES];
   logic [PAGE_BITS-1:0]  frame_c  [TABLE_ENTRIES];
   logic [IDX_W-1:0]      bidx_c   [TABLE_ENTRIES];
   logic [STAMP_BITS-1:0] bstamp_c [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] active;

   logic                  fill_en;
   logic [IDX_W-1:0]      fill_idx;
   logic [PAGE_BITS-1:0]  fill_tag, fill_frame;
   logic [STAMP_BITS-1:0] fill_stamp;

   genvar i;
   generate
      for (i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
         assign active[i] = (CNT_W'(i) < eff_count);
         if (i == 0) begin : g_head
            ftlb_cell #(
               .IDX_W(IDX_W), .PAGE_BITS(PAGE_BITS), .STAMP_BITS(STAMP_BITS),
               .CELL_INDEX(i)
            ) u_cell (
               .clock(clock), .reset(reset), .active(active[i]),
               .in_tok(head_tok),
               .in_vpage(req_tdata[PAGE_BITS-1:0]),
               .in_ppage(req_tdata[2*PAGE_BITS-1:PAGE_BITS]),
               .in_stamp(req_tdata[2*PAGE_BITS+STAMP_BITS-1:2*PAGE_BITS]),
               .in_frame('0), .in_best_idx('0), .in_best_stamp('1),
               .out_tok(tok_c[i]), .out_vpage(vpage_c[i]), .out_ppage(ppage_c[i]),
               .out_stamp(stamp_c[i]), .out_frame(frame_c[i]),
               .out_best_idx(bidx_c[i]), .out_best_stamp(bstamp_c[i]),
               .fill_en(fill_en), .fill_idx(fill_idx), .fill_tag(fill_tag),
               .fill_frame(fill_frame), .fill_stamp(fill_stamp)
            );
         end else begin : g_body
            ftlb_cell #(
               .IDX_W(IDX_W), .PAGE_BITS(PAGE_BITS), .STAMP_BITS(STAMP_BITS),
               .CELL_INDEX(i)
            ) u_cell (
               .clock(clock), .reset(reset), .active(active[i]),
               .in_tok(tok_c[i-1]), .in_vpage(vpage_c[i-1]), .in_ppage(ppage_c[i-1]),
               .in_stamp(stamp_c[i-1]), .in_frame(frame_c[i-1]),
               .in_best_idx(bidx_c[i-1]), .in_best_stamp(bstamp_c[i-1]),
               .out_tok(tok_c[i]), .out_vpage(vpage_c[i]), .out_ppage(ppage_c[i]),
               .out_stamp(stamp_c[i]), .out_frame(frame_c[i]),
               .out_best_idx(bidx_c[i]), .out_best_stamp(bstamp_c[i]),
               .fill_en(fill_en), .fill_idx(fill_idx), .fill_tag(fill_tag),
               .fill_frame(fill_frame), .fill_stamp(fill_stamp)
            );
         end
      end
   endgenerate

   // sequencer, counters and response register
   logic                  rsp_found;
   logic [PAGE_BITS-1:0]  rsp_page;
   logic [ftlb_pkg::COUNT_BITS-1:0] rsp_hits, rsp_misses;

   ftlb_ctrl #(
      .IDX_W(IDX_W), .PAGE_BITS(PAGE_BITS), .STAMP_BITS(STAMP_BITS)
   ) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_tvalid), .req_ready(req_tready),
      .tail_tok(tok_c[TABLE_ENTRIES-1]),
      .tail_vpage(vpage_c[TABLE_ENTRIES-1]),
      .tail_ppage(ppage_c[TABLE_ENTRIES-1]),
      .tail_stamp(stamp_c[TABLE_ENTRIES-1]),
      .tail_frame(frame_c[TABLE_ENTRIES-1]),
      .tail_best_idx(bidx_c[TABLE_ENTRIES-1]),
      .fill_en(fill_en), .fill_idx(fill_idx), .fill_tag(fill_tag),
      .fill_frame(fill_frame), .fill_stamp(fill_stamp),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_found(rsp_found), .rsp_page(rsp_page),
      .rsp_hits(rsp_hits), .rsp_misses(rsp_misses)
   );

   assign rsp_tuser = rsp_found;
   assign rsp_tdata = OUT_W'({rsp_misses, rsp_hits, rsp_page});

endmodule

@@ design/ftlb_cell.sv @@
module ftlb_cell #(
   parameter int IDX_W      = 4,
   parameter int PAGE_BITS  = 20,
   parameter int STAMP_BITS = 32,
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  active,
   // token from the previous cell
   input  ftlb_pkg::ftlb_tok_type in_tok,
   input  logic [PAGE_BITS-1:0]  in_vpage,
   input  logic [PAGE_BITS-1:0]  in_ppage,
   input  logic [STAMP_BITS-1:0] in_stamp,
   input  logic [PAGE_BITS-1:0]  in_frame,
   input  logic [IDX_W-1:0]      in_best_idx,
   input  logic [STAMP_BITS-1:0] in_best_stamp,
   // token to the next cell
   output ftlb_pkg::ftlb_tok_type out_tok,
   output logic [PAGE_BITS-1:0]  out_vpage,
   output logic [PAGE_BITS-1:0]  out_ppage,
   output logic [STAMP_BITS-1:0] out_stamp,
   output logic [PAGE_BITS-1:0]  out_frame,
   output logic [IDX_W-1:0]      out_best_idx,
   output logic [STAMP_BITS-1:0] out_best_stamp,
   // insert write
   input  logic                  fill_en,
   input  logic [IDX_W-1:0]      fill_idx,
   input  logic [PAGE_BITS-1:0]  fill_tag,
   input  logic [PAGE_BITS-1:0]  fill_frame,
   input  logic [STAMP_BITS-1:0] fill_stamp
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   // entry storage
   logic                  valid_ff, valid_in;
   logic [PAGE_BITS-1:0]  tag_ff, tag_in;
   logic [PAGE_BITS-1:0]  frame_ff, frame_in;
   logic [STAMP_BITS-1:0] last_ff, last_in;

   // token stage
   ftlb_pkg::ftlb_tok_type tok_ff, tok_in;
   logic [PAGE_BITS-1:0]  vpage_ff, ppage_ff, tframe_ff, tframe_in;
   logic [STAMP_BITS-1:0] stamp_ff, bstamp_ff, bstamp_in;
   logic [IDX_W-1:0]      bidx_ff, bidx_in;

   logic live;
   logic match;

   assign live  = in_tok.valid && active && !in_tok.done;
   assign match = live && valid_ff && (tag_ff == in_vpage);

   // work on the passing token and on the entry
   always_comb begin
      tok_in    = in_tok;
      tframe_in = in_frame;
      bidx_in   = in_best_idx;
      bstamp_in = in_best_stamp;
      valid_in  = valid_ff;
      tag_in    = tag_ff;
      frame_in  = frame_ff;
      last_in   = last_ff;
      case (in_tok.op)
         ftlb_pkg::OP_LOOKUP: begin
            if (match) begin
               tok_in.done = 1'b1;
               tframe_in   = frame_ff;
               last_in     = in_stamp;
            end
         end
         ftlb_pkg::OP_ERASE: begin
            if (match) begin
               tok_in.done = 1'b1;
               valid_in    = 1'b0;
            end
         end
         ftlb_pkg::OP_INSERT: begin
            if (live) begin
               if (!valid_ff) begin
                  tok_in.done = 1'b1;
                  bidx_in     = MY_IDX;
               end else if (last_ff < in_best_stamp) begin
                  bidx_in   = MY_IDX;
                  bstamp_in = last_ff;
               end
            end
         end
         default: begin
         end
      endcase
      // insert write from the sequencer, never while a token is in flight
      if (fill_en && (fill_idx == MY_IDX)) begin
         valid_in = 1'b1;
         tag_in   = fill_tag;
         frame_in = fill_frame;
         last_in  = fill_stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff      <= tag_in;
      frame_ff    <= frame_in;
      last_ff     <= last_in;
      vpage_ff    <= in_vpage;
      ppage_ff    <= in_ppage;
      stamp_ff    <= in_stamp;
      tframe_ff   <= tframe_in;
      bidx_ff     <= bidx_in;
      bstamp_ff   <= bstamp_in;
   end

   assign out_tok        = tok_ff;
   assign out_vpage      = vpage_ff;
   assign out_ppage      = ppage_ff;
   assign out_stamp      = stamp_ff;
   assign out_frame      = tframe_ff;
   assign out_best_idx   = bidx_ff;
   assign out_best_stamp = bstamp_ff;

endmodule

@@ design/ftlb_ctrl.sv @@
module ftlb_ctrl #(
   parameter int IDX_W      = 4,
   parameter int PAGE_BITS  = 20,
   parameter int STAMP_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   // token leaving the last cell
   input  ftlb_pkg::ftlb_tok_type tail_tok,
   input  logic [PAGE_BITS-1:0]  tail_vpage,
   input  logic [PAGE_BITS-1:0]  tail_ppage,
   input  logic [STAMP_BITS-1:0] tail_stamp,
   input  logic [PAGE_BITS-1:0]  tail_frame,
   input  logic [IDX_W-1:0]      tail_best_idx,
   // insert write to the cells
   output logic                  fill_en,
   output logic [IDX_W-1:0]      fill_idx,
   output logic [PAGE_BITS-1:0]  fill_tag,
   output logic [PAGE_BITS-1:0]  fill_frame,
   output logic [STAMP_BITS-1:0] fill_stamp,
   // result register
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic [PAGE_BITS-1:0]  rsp_page,
   output logic [ftlb_pkg::COUNT_BITS-1:0] rsp_hits,
   output logic [ftlb_pkg::COUNT_BITS-1:0] rsp_misses
);

   ftlb_pkg::ftlb_state_type state_ff, state_in;

   logic [1:0]            hold_op_ff;
   logic                  hold_done_ff;
   logic [PAGE_BITS-1:0]  hold_vpage_ff, hold_ppage_ff, hold_frame_ff;
   logic [STAMP_BITS-1:0] hold_stamp_ff;
   logic [IDX_W-1:0]      hold_idx_ff;

   logic [ftlb_pkg::COUNT_BITS-1:0] hit_ff, hit_in, miss_ff, miss_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_found_ff, out_found_in;
   logic [PAGE_BITS-1:0]  out_page_ff, out_page_in;
   logic [ftlb_pkg::COUNT_BITS-1:0] out_hits_ff, out_misses_ff;

   logic capture;
   logic finish;
   logic is_lookup;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ftlb_pkg::ST_IDLE:   if (req_valid) state_in = ftlb_pkg::ST_SCAN;
         ftlb_pkg::ST_SCAN:   if (tail_tok.valid) state_in = ftlb_pkg::ST_FINISH;
         ftlb_pkg::ST_FINISH: if (!out_valid_ff || rsp_ready) state_in = ftlb_pkg::ST_IDLE;
         default:             state_in = ftlb_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      capture   = 1'b0;
      finish    = 1'b0;
      unique case (state_ff)
         ftlb_pkg::ST_IDLE:   req_ready = 1'b1;
         ftlb_pkg::ST_SCAN:   capture   = tail_tok.valid;
         ftlb_pkg::ST_FINISH: finish    = !out_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   assign is_lookup = (hold_op_ff == ftlb_pkg::OP_LOOKUP);

   // insert write and counter update when the result is released
   always_comb begin
      fill_en      = finish && (hold_op_ff == ftlb_pkg::OP_INSERT);
      fill_idx     = hold_idx_ff;
      fill_tag     = hold_vpage_ff;
      fill_frame   = hold_ppage_ff;
      fill_stamp   = hold_stamp_ff;
      hit_in       = hit_ff;
      miss_in      = miss_ff;
      if (finish && is_lookup) begin
         if (hold_done_ff) hit_in  = hit_ff + 1'b1;
         else              miss_in = miss_ff + 1'b1;
      end
      out_found_in = is_lookup && hold_done_ff;
      out_page_in  = out_found_in ? hold_frame_ff : '0;
      out_valid_in = finish || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ftlb_pkg::ST_IDLE;
         hit_ff       <= '0;
         miss_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // token capture and result payload
   always_ff @(posedge clock) begin
      if (capture) begin
         hold_op_ff    <= tail_tok.op;
         hold_done_ff  <= tail_tok.done;
         hold_vpage_ff <= tail_vpage;
         hold_ppage_ff <= tail_ppage;
         hold_stamp_ff <= tail_stamp;
         hold_frame_ff <= tail_frame;
         hold_idx_ff   <= tail_best_idx;
      end
      if (finish) begin
         out_found_ff  <= out_found_in;
         out_page_ff   <= out_page_in;
         out_hits_ff   <= hit_in;
         out_misses_ff <= miss_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_found  = out_found_ff;
   assign rsp_page   = out_page_ff;
   assign rsp_hits   = out_hits_ff;
   assign rsp_misses = out_misses_ff;

endmodule

@@ design/ftlb_checker.sv @@
`include "assert_macros.svh"

module ftlb_checker #(
   parameter int PAGE_BITS = 20,
   parameter int RSP_W     = 88
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic             rsp_tuser,
   input logic [RSP_W-1:0] rsp_tdata
);

   // one request in flight: an accepted request closes the input
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

   // a miss or a non-lookup reports page zero
   `ASSERT_IMPLY(a_page_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[PAGE_BITS-1:0] == '0)

   // no response appears right out of reset
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

   // a stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind fully_associative_tlb_lru ftlb_checker #(
   .PAGE_BITS(PAGE_BITS),
   .RSP_W(((PAGE_BITS+2*ftlb_pkg::COUNT_BITS+7)/8)*8)
) u_ftlb_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata)
);

@@ bench/fully_associative_tlb_lru_tb.sv @@
module fully_associative_tlb_lru_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_ENTRIES  = 16;
   localparam int PAGE_BITS      = 20;
   localparam int STAMP_BITS     = 32;
   localparam int COUNT_BITS     = ftlb_pkg::COUNT_BITS;
   localparam int CSR_DATA_BITS  = ftlb_pkg::CSR_DATA_BITS;
   localparam int ENTRY_CNT_BITS = ftlb_pkg::ENTRY_CNT_BITS;
   localparam int REQ_BITS       = ((2*PAGE_BITS+STAMP_BITS+7)/8)*8;
   localparam int RSP_BITS       = ((PAGE_BITS+2*COUNT_BITS+7)/8)*8;

   // code with no operation behind it
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // byte addresses: the one register, and a slot with nothing behind it
   localparam logic [2:0] ADDR_ENTRIES  = {ftlb_pkg::CSR_ENTRIES_IN_USE, 2'b00};
   localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

   localparam int IDLE_PERCENT    = 36;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int STALL_LIMIT     = 3000;
   localparam int SETTLE_CYCLES   = TABLE_ENTRIES + 4;

   typedef struct packed {
      logic                  found;
      logic [PAGE_BITS-1:0]  page;
      logic [COUNT_BITS-1:0] hits;
      logic [COUNT_BITS-1:0] misses;
   } xlate_result_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [1:0] req_tuser;
   logic [REQ_BITS-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic rsp_tuser;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic psel;
   logic penable;
   logic pwrite;
   logic [2:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic pready;

   fully_associative_tlb_lru #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .PAGE_BITS(PAGE_BITS),
      .STAMP_BITS(STAMP_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // shadow copy of the translation table
   logic                   tlb_valid [TABLE_ENTRIES];
   logic [PAGE_BITS-1:0]   tlb_tag   [TABLE_ENTRIES];
   logic [PAGE_BITS-1:0]   tlb_frame [TABLE_ENTRIES];
   logic [STAMP_BITS-1:0]  tlb_stamp [TABLE_ENTRIES];
   logic [COUNT_BITS-1:0]  hit_count;
   logic [COUNT_BITS-1:0]  miss_count;
   logic [ENTRY_CNT_BITS-1:0] entries_cfg;

   xlate_result_type pending_translations[$];
   int error_count;
   int quiet_cycles;
   bit idle_enable;
   bit hold_off_request;
   logic [STAMP_BITS-1:0] stamp_clock;
   logic [PAGE_BITS-1:0]  page_pool [32];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Table update for one request; returns the response it should produce.
   function automatic xlate_result_type predict_translation(input logic [1:0] op,
                                                          input logic [PAGE_BITS-1:0] vpage,
                                                          input logic [PAGE_BITS-1:0] ppage,
                                                          input logic [STAMP_BITS-1:0] stamp);
      xlate_result_type r;
      int span;
      int slot;
      bit free_found;
      r = '0;
      span = (entries_cfg == 0) ? 1 : (entries_cfg > TABLE_ENTRIES) ? TABLE_ENTRIES
                                                                     : int'(entries_cfg);
      slot = -1;
      free_found = 1'b0;
      // first valid entry with a matching tag
      for (int i = 0; i < span; i++)
         if (slot < 0 && tlb_valid[i] && tlb_tag[i] == vpage)
            slot = i;
      case (op)
         ftlb_pkg::OP_LOOKUP: begin
            if (slot >= 0) begin
               tlb_stamp[slot] = stamp;
               hit_count = hit_count + 1'b1;
               r.found = 1'b1;
               r.page = tlb_frame[slot];
            end else begin
               miss_count = miss_count + 1'b1;
            end
         end
         ftlb_pkg::OP_INSERT: begin
            // first free entry, else oldest stamp with lowest index on a tie
            slot = 0;
            for (int i = 0; i < span; i++) begin
               if (!free_found) begin
                  if (!tlb_valid[i]) begin
                     slot = i;
                     free_found = 1'b1;
                  end else if (tlb_stamp[i] < tlb_stamp[slot]) begin
                     slot = i;
                  end
               end
            end
            tlb_valid[slot] = 1'b1;
            tlb_tag[slot] = vpage;
            tlb_frame[slot] = ppage;
            tlb_stamp[slot] = stamp;
         end
         ftlb_pkg::OP_ERASE: begin
            if (slot >= 0)
               tlb_valid[slot] = 1'b0;
         end
         default: ;
      endcase
      r.hits = hit_count;
      r.misses = miss_count;
      return r;
   endfunction

   // Monitor: check responses, predict accepted requests, track register writes.
   always @(posedge clock) begin
      xlate_result_type want;
      xlate_result_type got;
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++)
            tlb_valid[i] = 1'b0;
         hit_count = '0;
         miss_count = '0;
         entries_cfg = ftlb_pkg::ENTRIES_RESET;
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            quiet_cycles = 0;
            got.found = rsp_tuser;
            got.page = rsp_tdata[PAGE_BITS-1:0];
            got.hits = rsp_tdata[PAGE_BITS +: COUNT_BITS];
            got.misses = rsp_tdata[PAGE_BITS+COUNT_BITS +: COUNT_BITS];
            if (pending_translations.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = pending_translations.pop_front();
               if (got.found !== want.found) begin
                  $error("found: expected %0h, actual %0h", want.found, got.found);
                  error_count++;
               end
               if (got.page !== want.page) begin
                  $error("translated_page: expected %0h, actual %0h", want.page, got.page);
                  error_count++;
               end
               if (got.hits !== want.hits) begin
                  $error("hit_total: expected %0d, actual %0d", want.hits, got.hits);
                  error_count++;
               end
               if (got.misses !== want.misses) begin
                  $error("miss_total: expected %0d, actual %0d", want.misses, got.misses);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            quiet_cycles = 0;
            pending_translations.push_back(predict_translation(req_tuser,
               req_tdata[PAGE_BITS-1:0], req_tdata[PAGE_BITS +: PAGE_BITS],
               req_tdata[2*PAGE_BITS +: STAMP_BITS]));
         end
         if (psel && penable && pwrite && pready && paddr == ADDR_ENTRIES)
            entries_cfg = pwdata[ENTRY_CNT_BITS-1:0];
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("fully_associative_tlb_lru_tb NOT OK");
            $finish;
         end
      end
   end

   // Response side: random backpressure, plus one long hold-off on demand.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            rsp_tready <= !(idle_enable && $urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   // Offer one request and wait until it is taken; valid stays up afterwards.
   task automatic send_request(input logic [1:0] op, input logic [PAGE_BITS-1:0] vpage,
                               input logic [PAGE_BITS-1:0] ppage,
                               input logic [STAMP_BITS-1:0] stamp);
      while (idle_enable && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {stamp, ppage, vpage};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait for every response, then let the pipeline settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_translations.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [CSR_DATA_BITS-1:0] data);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic logic [STAMP_BITS-1:0] next_stamp();
      // mostly rising stamps with repeats for ties; now and then anything
      if ($urandom_range(0, 9) == 0)
         stamp_clock = $urandom();
      else
         stamp_clock = stamp_clock + $urandom_range(0, 2);
      return stamp_clock;
   endfunction

   // One random request biased toward pages that are likely in the table.
   task automatic send_random_request();
      logic [1:0] op;
      logic [PAGE_BITS-1:0] vpage;
      int pick;
      pick = $urandom_range(0, 99);
      op = (pick < 40) ? ftlb_pkg::OP_LOOKUP : (pick < 75) ? ftlb_pkg::OP_INSERT
         : (pick < 95) ? ftlb_pkg::OP_ERASE : OP_UNUSED;
      if ($urandom_range(0, 9) < 8)
         vpage = page_pool[$urandom_range(0, 31)];
      else
         vpage = PAGE_BITS'($urandom());
      send_request(op, vpage, PAGE_BITS'($urandom()), next_stamp());
   endtask

   // Each operation at the field extremes, duplicate tags, misses and the unused code.
   task automatic test_basic_ops();
      send_request(ftlb_pkg::OP_LOOKUP, 20'h00000, 20'h00000, 32'd1);
      send_request(ftlb_pkg::OP_INSERT, 20'h00000, 20'h00000, 32'd0);
      send_request(ftlb_pkg::OP_LOOKUP, 20'h00000, 20'hFFFFF, 32'd2);
      send_request(ftlb_pkg::OP_INSERT, 20'hFFFFF, 20'hFFFFF, 32'hFFFF_FFFF);
      send_request(ftlb_pkg::OP_LOOKUP, 20'hFFFFF, 20'h00000, 32'hFFFF_FFFF);
      send_request(ftlb_pkg::OP_INSERT, 20'h00000, 20'h12345, 32'd3);
      send_request(ftlb_pkg::OP_LOOKUP, 20'h00000, 20'h00000, 32'd4);
      send_request(ftlb_pkg::OP_ERASE,  20'h00000, 20'h00000, 32'd5);
      send_request(ftlb_pkg::OP_LOOKUP, 20'h00000, 20'h00000, 32'd6);
      send_request(ftlb_pkg::OP_ERASE,  20'hFFFFF, 20'hFFFFF, 32'hFFFF_FFFF);
      send_request(ftlb_pkg::OP_LOOKUP, 20'hFFFFF, 20'h00000, 32'd7);
      send_request(ftlb_pkg::OP_ERASE,  20'hABCDE, 20'h00000, 32'd8);
      send_request(OP_UNUSED, 20'hFFFFF, 20'hFFFFF, 32'hFFFF_FFFF);
      wait_idle();
   endtask

   // Two entries in use: eviction by oldest stamp, tie to the lower index.
   task automatic test_replacement_order();
      write_csr(ADDR_ENTRIES, 32'd2);
      send_request(ftlb_pkg::OP_INSERT, 20'h11111, 20'hAAAAA, 32'd5);
      send_request(ftlb_pkg::OP_INSERT, 20'h22222, 20'hBBBBB, 32'd5);
      send_request(ftlb_pkg::OP_INSERT, 20'h33333, 20'hCCCCC, 32'd9);
      send_request(ftlb_pkg::OP_LOOKUP, 20'h11111, 20'h00000, 32'd10);
      send_request(ftlb_pkg::OP_LOOKUP, 20'h22222, 20'h00000, 32'd1);
      send_request(ftlb_pkg::OP_INSERT, 20'h44444, 20'hDDDDD, 32'd7);
      send_request(ftlb_pkg::OP_LOOKUP, 20'h33333, 20'h00000, 32'd11);
      send_request(ftlb_pkg::OP_LOOKUP, 20'h22222, 20'h00000, 32'd12);
      wait_idle();
   endtask

   // Random traffic under a range of entry counts, including out-of-range ones.
   task automatic test_random_traffic();
      logic [CSR_DATA_BITS-1:0] settings [7];
      settings = '{32'd16, 32'd0, 32'd31, 32'd4, 32'd1, 32'hFFFF_FFE3, 32'd16};
      page_pool[0] = '0;
      page_pool[1] = '1;
      for (int i = 2; i < 32; i++)
         page_pool[i] = PAGE_BITS'($urandom());
      stamp_clock = $urandom_range(0, 1000);
      foreach (settings[k]) begin
         write_csr(ADDR_ENTRIES, settings[k]);
         // a write to an unmapped slot must leave the count alone
         if (k == 3)
            write_csr(ADDR_UNMAPPED, 32'd1);
         // first phase runs without any idling on either side
         idle_enable = (k != 0);
         repeat ((k == 0) ? 220 : 120) send_random_request();
         wait_idle();
      end
      idle_enable = 1'b1;
   endtask

   // Long response hold-off while requests keep coming, so the input stalls.
   task automatic test_backpressure();
      hold_off_request = 1'b1;
      repeat (12) send_random_request();
      wait_idle();
   endtask

   initial begin
      error_count = 0;
      idle_enable = 1'b1;
      hold_off_request = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= ftlb_pkg::OP_LOOKUP;
      req_tdata <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_replacement_order();
      test_random_traffic();
      test_backpressure();

      if (error_count == 0)
         $display("fully_associative_tlb_lru_tb OK");
      else
         $display("fully_associative_tlb_lru_tb NOT OK");
      $finish;
   end

endmodule
